// ----- rtl/lph_pkg.sv -----
`timescale 1ns / 1ps

package lph_pkg;

  localparam int KEY_W  = 31;
  localparam int REF_W  = 32;
  localparam int SLOT_W = 12;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_SEARCH = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  localparam logic [2:0] RS_STORED   = 3'd0;
  localparam logic [2:0] RS_DUP      = 3'd1;
  localparam logic [2:0] RS_FULL     = 3'd2;
  localparam logic [2:0] RS_FOUND    = 3'd3;
  localparam logic [2:0] RS_NOTFOUND = 3'd4;
  localparam logic [2:0] RS_DELETED  = 3'd5;

  localparam logic [1:0] ST_NEVER = 2'd0;
  localparam logic [1:0] ST_USED  = 2'd1;
  localparam logic [1:0] ST_TOMB  = 2'd2;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [KEY_W-1:0] key;
    logic [REF_W-1:0] sender_ref;
    logic [REF_W-1:0] receiver_ref;
    logic [REF_W-1:0] origin_ref;
    logic [REF_W-1:0] destination_ref;
  } in_req_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [SLOT_W-1:0] slot_index;
    logic [REF_W-1:0]  found_sender;
    logic [REF_W-1:0]  found_receiver;
    logic [REF_W-1:0]  found_origin;
    logic [REF_W-1:0]  found_destination;
  } out_rsp_t;

  typedef struct packed {
    logic [REF_W-1:0] sender;
    logic [REF_W-1:0] receiver;
    logic [REF_W-1:0] origin;
    logic [REF_W-1:0] destination;
  } payload_t;

  typedef struct packed {
    logic [1:0]       st;
    logic [KEY_W-1:0] key;
    payload_t         pay;
  } slot_row_t;

  typedef struct packed {
    logic [1:0]        opcode;
    logic              probe;
    logic [KEY_W-1:0]  key;
    logic [SLOT_W-1:0] home;
    payload_t          pay;
  } job_t;

  typedef enum logic [1:0] {
    FE_IDLE,
    FE_HASH,
    FE_PUSH
  } fe_state_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_PROBE,
    BK_RESP
  } bk_state_t;

endpackage

// ----- rtl/lph_ram.sv -----
`timescale 1ns / 1ps

module lph_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/lph_front.sv -----
`timescale 1ns / 1ps

module lph_front #(
  parameter int TABLE_SIZE = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  lph_pkg::in_req_t in_req,
  input  logic            init_done,
  output logic            push,
  output lph_pkg::job_t   push_job,
  input  logic            q_full
);

  import lph_pkg::*;

  localparam int REM_W = $clog2(TABLE_SIZE) + 1;
  localparam logic [REM_W-1:0] MODULUS = REM_W'(TABLE_SIZE);
  localparam logic [KEY_W-1:0] MOD_K   = KEY_W'(TABLE_SIZE);
  localparam logic [KEY_W-1:0] RECIP   = KEY_W'((64'd1 << KEY_W) / 64'(TABLE_SIZE));

  fe_state_t          fe_state_r, fe_state_nxt;
  job_t               job_r;
  logic [2*KEY_W-1:0] prod_r;
  logic [KEY_W-1:0]   quot, diff;
  logic [REM_W-1:0]   rem_r, rem_fix;
  logic               cnt_r;
  logic               accept;

  assign accept = in_valid && !in_stall;

  always_comb begin
    fe_state_nxt = fe_state_r;
    unique case (fe_state_r)
      FE_IDLE: begin
        if (accept) fe_state_nxt = FE_HASH;
      end
      FE_HASH: begin
        if (cnt_r) fe_state_nxt = FE_PUSH;
      end
      FE_PUSH: begin
        if (!q_full) fe_state_nxt = FE_IDLE;
      end
      default: fe_state_nxt = FE_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (fe_state_r != FE_IDLE) || !init_done;
    push     = (fe_state_r == FE_PUSH) && !q_full;
  end

  // Quotient estimate from the reciprocal is low by at most one, so the
  // partial remainder stays below twice the table size; one subtract ends it.
  assign quot    = prod_r[2*KEY_W-1:KEY_W];
  assign diff    = job_r.key - quot * MOD_K;
  assign rem_fix = (rem_r >= MODULUS) ? rem_r - MODULUS : rem_r;

  always_comb begin
    push_job      = job_r;
    push_job.home = SLOT_W'(rem_fix);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fe_state_r <= FE_IDLE;
    end else begin
      fe_state_r <= fe_state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      job_r.opcode          <= in_req.opcode;
      job_r.probe           <= (in_req.opcode == OP_INSERT) || (in_req.opcode == OP_SEARCH) ||
                               (in_req.opcode == OP_REMOVE);
      job_r.key             <= in_req.key;
      job_r.home            <= '0;
      job_r.pay.sender      <= in_req.sender_ref;
      job_r.pay.receiver    <= in_req.receiver_ref;
      job_r.pay.origin      <= in_req.origin_ref;
      job_r.pay.destination <= in_req.destination_ref;
      cnt_r                 <= 1'b0;
    end else if (fe_state_r == FE_HASH) begin
      if (!cnt_r) begin
        prod_r <= (2*KEY_W)'(job_r.key) * (2*KEY_W)'(RECIP);
      end else begin
        rem_r <= diff[REM_W-1:0];
      end
      cnt_r <= ~cnt_r;
    end
  end

endmodule

// ----- rtl/lph_fifo.sv -----
`timescale 1ns / 1ps

module lph_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  lph_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output lph_pkg::job_t head
);

  import lph_pkg::*;

  job_t       ent_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full       = (cnt_r == 2'd2);
  assign head_valid = (cnt_r != 2'd0);
  assign head       = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= push_job;
    end
  end

endmodule

// ----- rtl/lph_back.sv -----
`timescale 1ns / 1ps

module lph_back #(
  parameter int TABLE_SIZE = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  lph_pkg::job_t    q_head,
  output logic             q_pop,
  output logic             init_done,
  output logic             out_valid,
  input  logic             out_stall,
  output lph_pkg::out_rsp_t out_rsp
);

  import lph_pkg::*;

  localparam int IW    = $clog2(TABLE_SIZE);
  localparam int ROW_W = $bits(slot_row_t);
  localparam logic [IW-1:0] LAST = IW'(TABLE_SIZE - 1);

  bk_state_t       bk_state_r, bk_state_nxt;
  job_t            job_r;
  logic [IW-1:0]   cur_r, cur_inc, clr_r, n_r;
  out_rsp_t        res_r, res_nxt, out_r;
  logic            out_valid_r;
  logic            load_out;

  logic             we;
  logic [IW-1:0]    waddr, raddr;
  logic [ROW_W-1:0] wdata, rdata;
  slot_row_t        row, wrow;
  logic             done, do_wr, lap_end, key_eq;

  lph_ram #(
    .WIDTH (ROW_W),
    .DEPTH (TABLE_SIZE)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign row      = slot_row_t'(rdata);
  assign cur_inc  = (cur_r == LAST) ? '0 : cur_r + 1'b1;
  assign lap_end  = (n_r == LAST);
  assign key_eq   = (row.key == job_r.key);
  assign load_out = (bk_state_r == BK_RESP) && (!out_valid_r || !out_stall);

  // Judge the slot whose read data is on the RAM output this cycle.
  always_comb begin
    done    = 1'b0;
    do_wr   = 1'b0;
    wrow    = row;
    res_nxt = '0;
    res_nxt.status = RS_NOTFOUND;
    case (job_r.opcode) inside
      OP_INSERT: begin
        if (row.st != ST_USED) begin
          done     = 1'b1;
          do_wr    = 1'b1;
          wrow.st  = ST_USED;
          wrow.key = job_r.key;
          wrow.pay = job_r.pay;
          res_nxt.status     = RS_STORED;
          res_nxt.slot_index = SLOT_W'(cur_r);
        end else if (key_eq) begin
          done = 1'b1;
          res_nxt.status     = RS_DUP;
          res_nxt.slot_index = SLOT_W'(cur_r);
        end
      end
      OP_SEARCH, OP_REMOVE: begin
        if (row.st == ST_USED && key_eq) begin
          done = 1'b1;
          res_nxt.slot_index = SLOT_W'(cur_r);
          if (job_r.opcode == OP_REMOVE) begin
            do_wr   = 1'b1;
            wrow.st = ST_TOMB;
            res_nxt.status = RS_DELETED;
          end else begin
            res_nxt.status            = RS_FOUND;
            res_nxt.found_sender      = row.pay.sender;
            res_nxt.found_receiver    = row.pay.receiver;
            res_nxt.found_origin      = row.pay.origin;
            res_nxt.found_destination = row.pay.destination;
          end
        end else if (row.st == ST_NEVER) begin
          done = 1'b1;
        end
      end
      default: done = 1'b1;
    endcase
    if (!done && lap_end) begin
      done = 1'b1;
      res_nxt.status = (job_r.opcode == OP_INSERT) ? RS_FULL : RS_NOTFOUND;
    end
  end

  always_comb begin
    bk_state_nxt = bk_state_r;
    unique case (bk_state_r)
      BK_CLEAR: begin
        if (clr_r == LAST) bk_state_nxt = BK_IDLE;
      end
      BK_IDLE: begin
        if (q_valid) bk_state_nxt = q_head.probe ? BK_PROBE : BK_RESP;
      end
      BK_PROBE: begin
        if (done) bk_state_nxt = BK_RESP;
      end
      BK_RESP: begin
        if (load_out) bk_state_nxt = BK_IDLE;
      end
      default: bk_state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = (bk_state_r == BK_IDLE) && q_valid;
    init_done = (bk_state_r != BK_CLEAR);
    we        = 1'b0;
    waddr     = cur_r;
    wdata     = ROW_W'(wrow);
    raddr     = cur_inc;
    unique case (bk_state_r)
      BK_CLEAR: begin
        we    = 1'b1;
        waddr = clr_r;
        wdata = '0;
      end
      BK_IDLE: begin
        raddr = IW'(q_head.home);
      end
      BK_PROBE: begin
        we = do_wr;
      end
      BK_RESP: begin
        raddr = cur_r;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bk_state_r  <= BK_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      bk_state_r <= bk_state_nxt;
      if (bk_state_r == BK_CLEAR) clr_r <= clr_r + 1'b1;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job_r <= q_head;
      cur_r <= IW'(q_head.home);
      n_r   <= '0;
      res_r <= {RS_NOTFOUND, {(SLOT_W + 4 * REF_W){1'b0}}};
    end else if (bk_state_r == BK_PROBE) begin
      if (done) begin
        res_r <= res_nxt;
      end else begin
        cur_r <= cur_inc;
        n_r   <= n_r + 1'b1;
      end
    end
    if (load_out) begin
      out_r <= res_r;
    end
  end

endmodule

// ----- rtl/linear_probe_hash_table.sv -----
`timescale 1ns / 1ps
// Open-addressing hash table with linear probing over TABLE_SIZE slots.
// Input channel (in_valid / in_stall / in_req): one request per handshake,
// opcode insert, search or remove with a key and four payload handles.
// Result channel (out_valid / out_stall / out_rsp): exactly one result per
// request, in request order: status, slot index and, on a hit of search,
// the stored handles.
// The front end reduces the key modulo TABLE_SIZE by reciprocal multiply
// (a registered product, then a registered remainder) and hands the request
// to a two-entry queue. The back end walks the probe path one slot per cycle
// from the table RAM, whose single registered read port sets the pace;
// hashing of the next request overlaps the probe of the current one.
// After reset the back end clears every slot to never-used, one slot per
// cycle; in_stall stays high until that is done.
// When the receiver stalls, the result holds in the output register, the
// back end waits and the queue and front end fill, and in_stall stays high.

module linear_probe_hash_table #(
  parameter int TABLE_SIZE = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  lph_pkg::in_req_t  in_req,
  output logic              out_valid,
  input  logic              out_stall,
  output lph_pkg::out_rsp_t out_rsp
);

  import lph_pkg::*;

  logic init_done, push, q_full, q_pop, q_valid;
  job_t push_job, q_head;

  lph_front #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .init_done (init_done),
    .push      (push),
    .push_job  (push_job),
    .q_full    (q_full)
  );

  lph_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  lph_back #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .init_done (init_done),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_rsp   (out_rsp)
  );

endmodule

// ----- rtl/lph_checker.sv -----
`timescale 1ns / 1ps

module lph_checker #(
  parameter int TABLE_SIZE = 16
) (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_stall,
  input lph_pkg::out_rsp_t out_rsp
);

  import lph_pkg::*;

  logic no_payload;
  assign no_payload = (out_rsp.found_sender == '0) && (out_rsp.found_receiver == '0) &&
                      (out_rsp.found_origin == '0) && (out_rsp.found_destination == '0);

  a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_rsp.status <= RS_DELETED))
    else $error("result status out of range");

  a_miss_no_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_rsp.status == RS_FULL || out_rsp.status == RS_NOTFOUND)
      |-> (out_rsp.slot_index == '0))
    else $error("miss result carries a slot index");

  a_payload_only_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_rsp.status != RS_FOUND) |-> no_payload)
    else $error("payload on a result other than found");

  a_slot_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_rsp.slot_index) < 32'(TABLE_SIZE)))
    else $error("slot index beyond table");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_rsp))
    else $error("stalled result dropped or changed");

endmodule

bind linear_probe_hash_table lph_checker #(.TABLE_SIZE(TABLE_SIZE)) u_lph_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_rsp   (out_rsp)
);
